[rtl/gre_pkg.sv]
// Shared types, codes and small functions for the glyph row expander.
// No dependencies; used by gre_ctrl, gre_datapath and glyph_row_expander.
package gre_pkg;

   localparam logic [1:0] KIND_STORE  = 2'd0;
   localparam logic [1:0] KIND_MAP    = 2'd1;
   localparam logic [1:0] KIND_RENDER = 2'd2;
   localparam logic [1:0] KIND_NONE   = 2'd3;

   localparam logic [1:0] SIZE_12 = 2'd0;
   localparam logic [1:0] SIZE_14 = 2'd1;
   localparam logic [1:0] SIZE_16 = 2'd2;
   localparam logic [1:0] SIZE_NONE = 2'd3;

   typedef struct packed {
      logic       clear_step;
      logic       wr_store;
      logic       wr_map;
      logic       start;
      logic       issue;
      logic       take;
      logic [5:0] byte_no;
      logic [5:0] take_no;
      logic       emit;
      logic [4:0] row_no;
      logic       last;
      logic [1:0] size_sel;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic present;
   } status_type;

   // bytes in a glyph record: width word plus pixel data
   function automatic logic [5:0] fetch_bytes(input logic [1:0] fs);
      logic [5:0] n;
      unique case (fs)
         SIZE_12: n = 6'd20;
         SIZE_14: n = 6'd30;
         default: n = 6'd34;
      endcase
      return n;
   endfunction

   function automatic logic [4:0] row_count(input logic [1:0] fs, input logic border,
                                            input logic missing);
      logic [4:0] n;
      if (missing) begin
         if (fs == SIZE_16) n = 5'd16;
         else n = border ? 5'd14 : 5'd12;
      end else begin
         unique case (fs)
            SIZE_12: n = 5'd12;
            SIZE_14: n = 5'd14;
            default: n = 5'd16;
         endcase
         if (border) n = n + 5'd2;
      end
      return n;
   endfunction

   // hollow box for a missing glyph, source rows before dilation
   function automatic logic [17:0] box_row(input logic [4:0] k);
      logic [17:0] r;
      if (k == 5'd2 || k == 5'd9) r = 18'h0FE00;
      else if (k >= 5'd3 && k <= 5'd8) r = 18'h08200;
      else r = 18'h0;
      return r;
   endfunction

   // horizontal part of the 3x3 dilation: column c lights c..c+2
   function automatic logic [17:0] spread(input logic [17:0] x);
      return x | (x >> 1) | (x >> 2);
   endfunction

endpackage

[rtl/gre_ctrl.sv]
// Controller for the glyph row expander: state machine, counters, font size.
// Depends on gre_pkg.
module gre_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [1:0]          req_kind,
   input  logic                req_border,
   input  logic                csr_we,
   input  logic [1:0]          csr_wdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output gre_pkg::cmd_type    cmd,
   input  gre_pkg::status_type status
);

   typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_MAP, S_FETCH, S_EMIT} state_type;

   state_type  state_ff;
   logic [1:0] font_ff;
   logic [5:0] cnt_ff;
   logic [4:0] k_ff;
   logic       border_ff, missing_ff, valid_ff;
   logic       accept, out_free;
   logic [4:0] nrows;
   logic [5:0] total;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !valid_ff || rsp_tready;
   assign nrows      = gre_pkg::row_count(font_ff, border_ff, missing_ff);
   assign total      = gre_pkg::fetch_bytes(font_ff);

   always_comb begin
      cmd            = '0;
      cmd.size_sel   = font_ff;
      cmd.byte_no    = cnt_ff;
      cmd.take_no    = cnt_ff - 6'd1;
      cmd.row_no     = k_ff;
      cmd.last       = (k_ff == nrows - 5'd1);
      cmd.clear_step = (state_ff == S_CLEAR);
      cmd.wr_store   = accept && (req_kind == gre_pkg::KIND_STORE);
      cmd.wr_map     = accept && (req_kind == gre_pkg::KIND_MAP);
      cmd.start      = accept && (req_kind == gre_pkg::KIND_RENDER)
                       && (font_ff != gre_pkg::SIZE_NONE);
      cmd.issue      = (state_ff == S_FETCH) && (cnt_ff < total);
      cmd.take       = (state_ff == S_FETCH) && (cnt_ff != 6'd0);
      cmd.emit       = (state_ff == S_EMIT) && out_free && (k_ff != nrows);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         font_ff    <= gre_pkg::SIZE_12;
         valid_ff   <= 1'b0;
         cnt_ff     <= '0;
         k_ff       <= '0;
         border_ff  <= 1'b0;
         missing_ff <= 1'b0;
      end else begin
         if (csr_we) font_ff <= csr_wdata;
         unique case (state_ff)
            S_CLEAR: begin
               if (status.clear_done) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (cmd.start) begin
                  border_ff <= req_border;
                  state_ff  <= S_MAP;
               end
            end
            S_MAP: begin
               missing_ff <= !status.present;
               cnt_ff     <= '0;
               k_ff       <= '0;
               state_ff   <= status.present ? S_FETCH : S_EMIT;
            end
            S_FETCH: begin
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == total) state_ff <= S_EMIT;
            end
            S_EMIT: begin
               if (out_free) begin
                  if (k_ff != nrows) begin
                     valid_ff <= 1'b1;
                     k_ff     <= k_ff + 5'd1;
                  end else begin
                     valid_ff <= 1'b0;
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

[rtl/gre_datapath.sv]
// Datapath for the glyph row expander: code map, glyph store, row buffer,
// dilation and the result register. Depends on gre_pkg.
module gre_datapath #(
   parameter int CODE_SPACE  = 65536,
   parameter int STORE_BYTES = 65536
) (
   input  logic                clock,
   input  logic                reset,
   input  gre_pkg::cmd_type    cmd,
   output gre_pkg::status_type status,
   input  logic [15:0]         req_index,
   input  logic [15:0]         req_value,
   input  logic                req_present,
   input  logic                req_border,
   output logic [4:0]          rsp_row,
   output logic [17:0]         rsp_pixels,
   output logic [15:0]         rsp_width,
   output logic                rsp_last
);

   localparam int MAW = $clog2(CODE_SPACE);
   localparam int SAW = $clog2(STORE_BYTES);
   localparam logic [16:0] CS_LIM = 17'(CODE_SPACE);
   localparam logic [16:0] SB_LIM = 17'(STORE_BYTES);
   localparam logic [MAW-1:0] CLR_LAST = MAW'(CODE_SPACE - 1);

   logic [16:0] map_mem [CODE_SPACE];
   logic [7:0]  store_mem [STORE_BYTES];

   logic [MAW-1:0] clr_ff;
   logic [16:0]    map_q_ff;
   logic           in_range_ff, border_ff, oor_ff;
   logic [7:0]     store_q_ff, lo_ff;
   logic [15:0]    width_ff;
   logic [1:0]     phase_ff;
   logic [3:0]     wr_ff;
   logic [17:0]    buf_ff [16];
   logic [17:0]    p1_ff, p2_ff;

   logic           map_we;
   logic [MAW-1:0] map_wa;
   logic [16:0]    map_wd, rd_addr;
   logic [7:0]     rd_byte;
   logic [17:0]    src, pix;
   logic [15:0]    wrow;

   assign status.clear_done = (clr_ff == CLR_LAST);
   assign status.present    = in_range_ff && map_q_ff[16];

   assign map_we  = cmd.clear_step || (cmd.wr_map && ({1'b0, req_index} < CS_LIM));
   assign map_wa  = cmd.clear_step ? clr_ff : req_index[MAW-1:0];
   assign map_wd  = cmd.clear_step ? 17'd0 : {req_present, req_value};
   assign rd_addr = {1'b0, map_q_ff[15:0]} + 17'(cmd.byte_no);
   assign rd_byte = oor_ff ? 8'd0 : store_q_ff;
   assign wrow    = {rd_byte, lo_ff};

   assign src = status.present ? buf_ff[0] : gre_pkg::box_row(cmd.row_no);
   assign pix = border_ff ? (gre_pkg::spread(src) | gre_pkg::spread(p1_ff)
                             | gre_pkg::spread(p2_ff)) : src;

   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (cmd.clear_step) clr_ff <= clr_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (map_we) map_mem[map_wa] <= map_wd;
      if (cmd.start) begin
         map_q_ff    <= map_mem[req_index[MAW-1:0]];
         in_range_ff <= ({1'b0, req_index} < CS_LIM);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_store && ({1'b0, req_index} < SB_LIM))
         store_mem[req_index[SAW-1:0]] <= req_value[7:0];
      if (cmd.issue) begin
         store_q_ff <= store_mem[rd_addr[SAW-1:0]];
         oor_ff     <= (rd_addr >= SB_LIM);
      end
   end

   // record decode, row buffer and result register
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         border_ff <= req_border;
         width_ff  <= 16'd12 + {13'd0, cmd.size_sel, 1'b0};
         phase_ff  <= '0;
         wr_ff     <= '0;
         p1_ff     <= '0;
         p2_ff     <= '0;
         for (int i = 0; i < 16; i++) buf_ff[i] <= '0;
      end else if (cmd.take) begin
         if (cmd.take_no == 6'd0) width_ff[7:0] <= rd_byte;
         else if (cmd.take_no == 6'd1) width_ff[15:8] <= rd_byte;
         else begin
            if (phase_ff == 2'd0) begin
               lo_ff    <= rd_byte;
               phase_ff <= 2'd1;
            end else if (cmd.size_sel == gre_pkg::SIZE_12) begin
               if (phase_ff == 2'd1) begin
                  buf_ff[wr_ff] <= {wrow[15:4], 6'd0};
                  phase_ff      <= 2'd2;
               end else begin
                  buf_ff[wr_ff] <= {lo_ff[3:0], rd_byte, 6'd0};
                  phase_ff      <= 2'd0;
               end
               wr_ff <= wr_ff + 4'd1;
            end else begin
               if (cmd.size_sel == gre_pkg::SIZE_14)
                  buf_ff[wr_ff] <= {wrow & 16'hFFFC, 2'd0};
               else
                  buf_ff[wr_ff] <= {wrow, 2'd0};
               phase_ff <= 2'd0;
               wr_ff    <= wr_ff + 4'd1;
            end
         end
      end else if (cmd.emit) begin
         for (int i = 0; i < 15; i++) buf_ff[i] <= buf_ff[i+1];
         buf_ff[15] <= '0;
         p1_ff      <= src;
         p2_ff      <= p1_ff;
         rsp_row    <= cmd.row_no;
         rsp_pixels <= pix;
         rsp_width  <= width_ff;
         rsp_last   <= cmd.last;
      end
   end

endmodule

[rtl/glyph_row_expander.sv]
// Top level of the glyph row expander: bitmap font character generator.
// Depends on gre_pkg, gre_ctrl and gre_datapath.
//
//  channel  | dir | handshake            | payload
//  req_     | in  | req_tvalid/tready    | tuser=kind, tdata=index,value,present,with_border
//  rsp_     | out | rsp_tvalid/tready    | tdata=row,pixels,width, tlast=last
//  csr_     | in  | csr_we               | csr_wdata=size_sel
//
// After reset the code map is swept clear with req_tready low. Store and map
// writes are made in the cycle they are accepted. A render does a map lookup
// (accept cycle plus decision), then (for a present glyph) byte reads through
// the single store read port, then loads the output register and sends its
// rows (12..18 rows). A low rsp_tready holds the current row; no new item is
// taken until the last row of a render is delivered.
module glyph_row_expander #(
   parameter int CODE_SPACE  = 65536,
   parameter int STORE_BYTES = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // index[15:0], value[31:16], present[32], with_border[33]
   input  logic [1:0]  req_tuser,   // kind[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // row[4:0], pixels[22:5], width[38:23]
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_wdata    // size_sel
);

   gre_pkg::cmd_type    cmd;
   gre_pkg::status_type status;
   logic [4:0]  row;
   logic [17:0] pixels;
   logic [15:0] width;

   gre_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .req_border (req_tdata[33]),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   gre_datapath #(
      .CODE_SPACE  (CODE_SPACE),
      .STORE_BYTES (STORE_BYTES)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_index   (req_tdata[15:0]),
      .req_value   (req_tdata[31:16]),
      .req_present (req_tdata[32]),
      .req_border  (req_tdata[33]),
      .rsp_row     (row),
      .rsp_pixels  (pixels),
      .rsp_width   (width),
      .rsp_last    (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, width, pixels, row};

   // input and output never active together: one item at a time
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input ready while a row is pending");

   // the final row handed over returns the block to accepting items
   a_back: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> req_tready)
      else $error("block did not return to idle after last row");

endmodule

[sim/gre_row_checker.sv]
`timescale 1ns / 100ps
// Row checker for the glyph row expander: watches the item and row channels,
// predicts each render's rows from its own store and map copy, compares them.
// Depends on gre_pkg for the kind and size codes.
module gre_row_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_wdata,
   output int          fail_count,
   output int          pending_count,
   output int          rows_checked
);

   typedef struct {
      logic [4:0]  row;
      logic [17:0] pixels;
      logic [15:0] width;
      logic        last;
   } row_item_type;

   row_item_type rows_due[$];
   logic [7:0]   store_copy[int];
   logic [16:0]  map_copy[int];
   logic [1:0]   size_now;

   function automatic logic [7:0] byte_at(input int unsigned a);
      if (a >= 65536) return 8'h0;
      return store_copy.exists(a) ? store_copy[a] : 8'h0;
   endfunction

   function automatic logic [15:0] word_at(input int unsigned a);
      return {byte_at(a + 1), byte_at(a)};
   endfunction

   function automatic logic [17:0] cols(input int c0, input int c1);
      logic [17:0] m;
      m = '0;
      for (int c = c0; c <= c1; c++) m[17 - c] = 1'b1;
      return m;
   endfunction

   task automatic dot(inout logic [17:0] img[18], input int r, input int c, input bit brd);
      if (brd) begin
         for (int d = 0; d < 3; d++)
            if (r + d < 18 && c <= 15) img[r + d] |= 18'h7 << (15 - c);
      end else if (r < 18 && c <= 17) begin
         img[r][17 - c] = 1'b1;
      end
   endtask

   task automatic queue_render(input logic [15:0] code, input bit brd);
      logic [17:0] img[18];
      logic [16:0] ent;
      logic [15:0] w, wid;
      int unsigned base, a;
      int nrows, n;
      row_item_type it;
      for (int i = 0; i < 18; i++) img[i] = '0;
      ent = map_copy.exists(code) ? map_copy[code] : 17'h0;
      if (!ent[16]) begin
         // hollow box stands in for a missing glyph
         wid = 16'd12 + 16'd2 * {14'd0, size_now};
         nrows = (size_now == gre_pkg::SIZE_16) ? 16 : (brd ? 14 : 12);
         for (int i = 0; i < nrows; i++) begin
            if (brd) begin
               if ((i >= 2 && i <= 4) || (i >= 9 && i <= 11)) img[i] = cols(2, 10);
               else if (i >= 5 && i <= 8) img[i] = cols(2, 4) | cols(8, 10);
            end else begin
               if (i == 2 || i == 9) img[i] = cols(2, 8);
               else if (i >= 3 && i <= 8) img[i] = cols(2, 2) | cols(8, 8);
            end
         end
      end else begin
         base = {16'd0, ent[15:0]};
         wid = word_at(base);
         base += 2;
         if (size_now == gre_pkg::SIZE_12) begin
            // interleaved: three bytes per row pair
            nrows = brd ? 14 : 12;
            for (int i = 0; i < 12; i += 2) begin
               a = base + (i / 2) * 3;
               w = word_at(a);
               for (int j = 0; j < 12; j++) if (w[15 - j]) dot(img, i, j, brd);
               for (int j = 0; j < 4; j++) if (w[3 - j]) dot(img, i + 1, j, brd);
               w = {8'h0, byte_at(a + 2)};
               for (int j = 0; j < 8; j++) if (w[7 - j]) dot(img, i + 1, j + 4, brd);
            end
         end else begin
            n = (size_now == gre_pkg::SIZE_14) ? 14 : 16;
            nrows = brd ? n + 2 : n;
            for (int i = 0; i < n; i++) begin
               w = word_at(base + i * 2);
               for (int j = 0; j < n; j++) if (w[15 - j]) dot(img, i, j, brd);
            end
         end
      end
      for (int i = 0; i < nrows; i++) begin
         it.row = i[4:0];
         it.pixels = img[i];
         it.width = wid;
         it.last = (i + 1 == nrows);
         rows_due.insert(rows_due.size(), it);
      end
   endtask

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      row_item_type want;
      if (reset) begin
         size_now <= gre_pkg::SIZE_12;
         map_copy.delete();
      end else begin
         if (csr_we) size_now <= csr_wdata;
         if (rsp_tvalid && rsp_tready) begin
            rows_checked++;
            if (rows_due.size() == 0) begin
               report("row without a pending render", rsp_tdata[31:0], 0);
            end else begin
               want = rows_due.pop_front();
               if (rsp_tdata[4:0] != want.row)
                  report("row", 32'(rsp_tdata[4:0]), 32'(want.row));
               if (rsp_tdata[22:5] != want.pixels)
                  report("pixels", 32'(rsp_tdata[22:5]), 32'(want.pixels));
               if (rsp_tdata[38:23] != want.width)
                  report("width", 32'(rsp_tdata[38:23]), 32'(want.width));
               if (rsp_tlast != want.last)
                  report("last", 32'(rsp_tlast), 32'(want.last));
            end
         end
         if (req_tvalid && req_tready) begin
            unique case (req_tuser)
               gre_pkg::KIND_STORE: store_copy[req_tdata[15:0]] = req_tdata[23:16];
               gre_pkg::KIND_MAP:
                  map_copy[req_tdata[15:0]] = {req_tdata[32], req_tdata[31:16]};
               gre_pkg::KIND_RENDER:
                  if (size_now != gre_pkg::SIZE_NONE)
                     queue_render(req_tdata[15:0], req_tdata[33]);
               default: ;
            endcase
         end
         pending_count = rows_due.size();
      end
   end

endmodule

[sim/glyph_row_expander_tb.sv]
`timescale 1ns / 100ps
// Testbench top for the glyph row expander: drives items, random gaps and
// font size phases; gre_row_checker does the prediction. Depends on gre_pkg.
module glyph_row_expander_tb;

   localparam int IDLE_LIMIT = 200000;   // covers the map sweep after reset

   logic        clock, reset;
   logic        req_tvalid = 1'b0, req_tready;
   logic [39:0] req_tdata = '0;
   logic [1:0]  req_tuser = gre_pkg::KIND_STORE;
   logic        rsp_tvalid, rsp_tready = 1'b0, rsp_tlast;
   logic [39:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_wdata = gre_pkg::SIZE_12;

   int fails, pending, rows_seen;
   int items_sent = 0, renders_sent = 0, idle_cycles = 0;
   bit burst_mode = 0;       // no gaps on the sender while set
   bit hold_rows = 0;        // receiver takes one long hold-off
   logic [15:0] mapped_codes[$];
   int slots[8] = '{0, 37, 500, 4096, 30000, 65500, 65520, 65530};

   glyph_row_expander uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   gre_row_checker row_chk (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .fail_count(fails), .pending_count(pending), .rows_checked(rows_seen)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   // watchdog: cycles with no handshake on either channel
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
         $display("Regression FAIL");
         $finish;
      end
   end

   // row receiver: random stall before each row, one long hold on request
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
         if (hold_rows) begin
            gap = 400;
            hold_rows = 0;
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   task automatic send(input logic [1:0] kind, input logic [15:0] idx, input logic [15:0] val,
                       input bit pres, input bit brd);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tuser <= kind;
      req_tdata <= {6'b0, brd, pres, val, idx};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (kind == gre_pkg::KIND_RENDER) renders_sent++;
   endtask

   // fill a whole glyph record at a slot (up to 34 bytes) and map a code to it
   task automatic load_glyph(input int slot_off, input logic [15:0] code);
      for (int a = slot_off; a < slot_off + 34 && a < 65536; a++)
         send(gre_pkg::KIND_STORE, a[15:0], 16'($urandom_range(0, 65535)),
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      send(gre_pkg::KIND_MAP, code, slot_off[15:0], 1'b1, 1'($urandom_range(0, 1)));
      mapped_codes.insert(mapped_codes.size(), code);
   endtask

   task automatic drain_and_set(input logic [1:0] fs);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);    // a trailing write may still be in flight
      csr_wdata <= fs;
      csr_we <= 1'b1;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_phase(input int count);
      int pick, stop_at;
      logic [15:0] code;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 19) == 0) burst_mode = ~burst_mode;
         pick = $urandom_range(0, 99);
         if (pick < 12 && items_sent + 35 <= stop_at) begin
            load_glyph(slots[$urandom_range(0, 7)], 16'($urandom_range(0, 65535)));
         end else if (pick < 70) begin
            if (mapped_codes.size() > 0 && $urandom_range(0, 3) != 0)
               code = mapped_codes[$urandom_range(0, mapped_codes.size() - 1)];
            else
               code = 16'($urandom_range(0, 65535));
            send(gre_pkg::KIND_RENDER, code, 16'($urandom_range(0, 65535)),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end else if (pick < 80) begin
            // random store writes are harmless: reads only hit loaded slots
            send(gre_pkg::KIND_STORE, 16'($urandom_range(0, 65535)),
                 16'($urandom_range(0, 65535)),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end else if (pick < 90) begin
            send(gre_pkg::KIND_MAP, 16'($urandom_range(0, 65535)),
                 16'($urandom_range(0, 65535)), 1'b0, 1'($urandom_range(0, 1)));
         end else begin
            send(gre_pkg::KIND_NONE, 16'($urandom_range(0, 65535)),
                 16'($urandom_range(0, 65535)),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end
      end
   endtask

   initial begin
      @(negedge reset);
      @(posedge clock);
      // directed: glyph at the store top, reads past the end come back 0
      for (int a = 65530; a < 65536; a++)
         send(gre_pkg::KIND_STORE, a[15:0], 16'hFFFF, 1'b1, 1'b1);
      send(gre_pkg::KIND_MAP, 16'hFFFF, 16'd65530, 1'b1, 1'b0);
      mapped_codes.insert(mapped_codes.size(), 16'hFFFF);
      send(gre_pkg::KIND_MAP, 16'h0000, 16'hFFFF, 1'b0, 1'b1);
      send(gre_pkg::KIND_RENDER, 16'hFFFF, 16'h0, 1'b0, 1'b0);
      send(gre_pkg::KIND_RENDER, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
      send(gre_pkg::KIND_RENDER, 16'h0000, 16'h0, 1'b0, 1'b0);
      send(gre_pkg::KIND_RENDER, 16'h0000, 16'h0, 1'b0, 1'b1);
      send(gre_pkg::KIND_NONE, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
      send(gre_pkg::KIND_STORE, 16'h0000, 16'h0000, 1'b0, 1'b0);

      random_phase(60);
      drain_and_set(gre_pkg::SIZE_16);
      send(gre_pkg::KIND_RENDER, 16'hFFFF, 16'h0, 1'b0, 1'b1);
      send(gre_pkg::KIND_RENDER, 16'h0000, 16'h0, 1'b0, 1'b1);
      hold_rows = 1;        // receiver holds rows off while items are still offered
      random_phase(60);
      drain_and_set(gre_pkg::SIZE_14);
      random_phase(50);
      drain_and_set(gre_pkg::SIZE_NONE);
      send(gre_pkg::KIND_RENDER, 16'hFFFF, 16'h0, 1'b0, 1'b1);
      random_phase(15);
      drain_and_set(gre_pkg::SIZE_12);
      random_phase(50);
      drain_and_set(gre_pkg::SIZE_16);
      random_phase(50);

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("Sent %0d items (%0d renders) over sizes 12, 14, 16 and the unused size;",
               items_sent, renders_sent);
      $display("checked %0d rows, %0d rows still owed, %0d mismatches.",
               rows_seen, pending, fails);
      if (fails == 0 && pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
